// File: hdl/assert_macros.svh
// Assertion macros for the checker file of the line rasterizer.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define AST_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define AST_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/mlr_pkg.sv
// Shared types and constants of the midpoint line rasterizer.
// No dependencies; imported by every module of the block.
package mlr_pkg;

    // Default geometry
    localparam int COORD_BITS_DEF  = 12;
    localparam int PATTERN_LEN_DEF = 4;
    localparam int QUEUE_DEPTH     = 2;

    // Dash pattern register
    localparam int               DASH_BITS  = 4;
    localparam logic [DASH_BITS-1:0] DASH_RESET = 4'hF;

    // Action codes carried in s_tuser
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    // Per-axis direction codes
    typedef logic signed [1:0] dir_t;
    localparam dir_t DIR_NONE = 2'sb00;
    localparam dir_t DIR_POS  = 2'sb01;
    localparam dir_t DIR_NEG  = 2'sb11;

    // Classified command from the front end
    typedef struct packed {
        logic is_start;
        logic x_major;
        dir_t x_dir;
        dir_t y_dir;
    } cmd_ctrl_t;

endpackage

// File: hdl/mlr_front.sv
// Front end: decodes one input beat and classifies a line start.
// Depends on mlr_pkg.
module mlr_front
    import mlr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  action,
    input  logic [COORD_BITS-1:0] x_start,
    input  logic [COORD_BITS-1:0] y_start,
    input  logic [COORD_BITS-1:0] x_end,
    input  logic [COORD_BITS-1:0] y_end,
    output cmd_ctrl_t             ctrl,
    output logic [COORD_BITS-1:0] x0,
    output logic [COORD_BITS-1:0] y0,
    output logic [COORD_BITS:0]   major,
    output logic [COORD_BITS:0]   minor
);
    localparam int MW = COORD_BITS + 1;

    logic signed [MW-1:0] dx;
    logic signed [MW-1:0] dy;
    logic [MW-1:0]        adx;
    logic [MW-1:0]        ady;
    logic                 x_major;

    // Deltas with one guard bit
    assign dx = $signed({x_end[COORD_BITS-1], x_end}) - $signed({x_start[COORD_BITS-1], x_start});
    assign dy = $signed({y_end[COORD_BITS-1], y_end}) - $signed({y_start[COORD_BITS-1], y_start});

    // Magnitudes fit unsigned in MW bits
    assign adx = dx[MW-1] ? MW'(-dx) : MW'(dx);
    assign ady = dy[MW-1] ? MW'(-dy) : MW'(dy);

    // Pick the major axis; ties go to y
    assign x_major = adx > ady;

    always_comb begin
        ctrl.is_start = (action == ACT_START);
        ctrl.x_major  = x_major;
        ctrl.x_dir    = (dx == '0) ? DIR_NONE : (dx[MW-1] ? DIR_NEG : DIR_POS);
        ctrl.y_dir    = (dy == '0) ? DIR_NONE : (dy[MW-1] ? DIR_NEG : DIR_POS);
    end

    assign x0    = x_start;
    assign y0    = y_start;
    assign major = x_major ? adx : ady;
    assign minor = x_major ? ady : adx;

endmodule

// File: hdl/mlr_queue.sv
// Small register queue between front end and stepper.
// Depends on mlr_pkg.
module mlr_queue
    import mlr_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entry payload
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// File: hdl/mlr_stepper.sv
// Back end: holds line state, runs one midpoint step per step beat, registers the result.
// Depends on mlr_pkg.
module mlr_stepper
    import mlr_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int PATTERN_LEN = PATTERN_LEN_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [DASH_BITS-1:0]  cfg_wdata,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  cmd_ctrl_t             q_ctrl,
    input  logic [COORD_BITS-1:0] q_x0,
    input  logic [COORD_BITS-1:0] q_y0,
    input  logic [COORD_BITS:0]   q_major,
    input  logic [COORD_BITS:0]   q_minor,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COORD_BITS-1:0] out_x,
    output logic [COORD_BITS-1:0] out_y,
    output logic                  out_visible,
    output logic                  out_last,
    output logic                  out_pix_valid
);
    localparam int MW        = COORD_BITS + 1;
    localparam int DW        = COORD_BITS + 4;
    localparam int PAT_W     = (PATTERN_LEN > 1) ? $clog2(PATTERN_LEN) : 1;
    localparam int PAT_SPAN  = 1 << PAT_W;

    // Line state
    logic [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic signed [DW-1:0]  dec_reg, dec_next;
    logic [MW-1:0]         major_reg, major_next;
    logic [MW-1:0]         minor_reg, minor_next;
    dir_t                  x_dir_reg, x_dir_next;
    dir_t                  y_dir_reg, y_dir_next;
    logic                  x_major_reg, x_major_next;
    logic [MW-1:0]         steps_reg, steps_next;
    logic [PAT_W-1:0]      pat_pos_reg, pat_pos_next;
    logic [DASH_BITS-1:0]  dash_reg;

    // Result register
    logic                  out_valid_reg, out_valid_next;
    logic [COORD_BITS-1:0] out_x_reg, out_x_next;
    logic [COORD_BITS-1:0] out_y_reg, out_y_next;
    logic                  out_vis_reg, out_vis_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_pv_reg, out_pv_next;

    logic                  pop;
    logic [PAT_SPAN-1:0]   dash_ext;
    logic [COORD_BITS-1:0] x_inc, y_inc;
    logic signed [DW-1:0]  two_minor, two_diff, q_dec_init;
    logic [COORD_BITS-1:0] step_x, step_y;
    logic signed [DW-1:0]  step_dec;

    // Pattern positions past the register width read as not drawn
    for (genvar i = 0; i < PAT_SPAN; i++) begin : g_dash
        if (i < DASH_BITS) begin : g_bit
            assign dash_ext[i] = dash_reg[i];
        end else begin : g_zero
            assign dash_ext[i] = 1'b0;
        end
    end

    // Take a queue entry when the result register is free or draining
    assign pop     = q_valid && (!out_valid_reg || out_ready);
    assign q_ready = !out_valid_reg || out_ready;

    // Step arithmetic on the current line
    assign x_inc      = {{(COORD_BITS-2){x_dir_reg[1]}}, x_dir_reg};
    assign y_inc      = {{(COORD_BITS-2){y_dir_reg[1]}}, y_dir_reg};
    assign two_minor  = $signed({{(DW-MW-1){1'b0}}, minor_reg, 1'b0});
    assign two_diff   = two_minor - $signed({{(DW-MW-1){1'b0}}, major_reg, 1'b0});
    assign q_dec_init = $signed({{(DW-MW-1){1'b0}}, q_minor, 1'b0})
                      - $signed({{(DW-MW){1'b0}}, q_major});

    always_comb begin
        step_x   = x_major_reg ? cur_x_reg + x_inc : cur_x_reg;
        step_y   = x_major_reg ? cur_y_reg : cur_y_reg + y_inc;
        step_dec = dec_reg + two_minor;
        if (!dec_reg[DW-1]) begin
            // Minor axis moves too
            if (x_major_reg) begin
                step_y = cur_y_reg + y_inc;
            end else begin
                step_x = cur_x_reg + x_inc;
            end
            step_dec = dec_reg + two_diff;
        end
    end

    // Next state and result
    always_comb begin
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        dec_next       = dec_reg;
        major_next     = major_reg;
        minor_next     = minor_reg;
        x_dir_next     = x_dir_reg;
        y_dir_next     = y_dir_reg;
        x_major_next   = x_major_reg;
        steps_next     = steps_reg;
        pat_pos_next   = pat_pos_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_vis_next   = out_vis_reg;
        out_last_next  = out_last_reg;
        out_pv_next    = out_pv_reg;
        if (pop) begin
            out_valid_next = 1'b1;
            if (q_ctrl.is_start) begin
                // Load a new line and show its start pixel
                cur_x_next    = q_x0;
                cur_y_next    = q_y0;
                dec_next      = q_dec_init;
                major_next    = q_major;
                minor_next    = q_minor;
                x_dir_next    = q_ctrl.x_dir;
                y_dir_next    = q_ctrl.y_dir;
                x_major_next  = q_ctrl.x_major;
                steps_next    = q_major;
                out_x_next    = q_x0;
                out_y_next    = q_y0;
                out_vis_next  = 1'b1;
                out_last_next = (q_major == '0);
                out_pv_next   = 1'b1;
            end else if (steps_reg == '0) begin
                // Line finished: empty result, state holds
                out_x_next    = '0;
                out_y_next    = '0;
                out_vis_next  = 1'b0;
                out_last_next = 1'b0;
                out_pv_next   = 1'b0;
            end else begin
                cur_x_next    = step_x;
                cur_y_next    = step_y;
                dec_next      = step_dec;
                steps_next    = steps_reg - 1'b1;
                pat_pos_next  = (pat_pos_reg == PAT_W'(PATTERN_LEN - 1)) ? '0
                                                                         : pat_pos_reg + 1'b1;
                out_x_next    = step_x;
                out_y_next    = step_y;
                out_vis_next  = dash_ext[pat_pos_reg];
                out_last_next = (steps_reg == MW'(1));
                out_pv_next   = 1'b1;
            end
        end
    end

    // Control state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            dec_reg       <= '0;
            major_reg     <= '0;
            minor_reg     <= '0;
            x_dir_reg     <= DIR_NONE;
            y_dir_reg     <= DIR_NONE;
            x_major_reg   <= 1'b0;
            steps_reg     <= '0;
            pat_pos_reg   <= '0;
            dash_reg      <= DASH_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            dec_reg       <= dec_next;
            major_reg     <= major_next;
            minor_reg     <= minor_next;
            x_dir_reg     <= x_dir_next;
            y_dir_reg     <= y_dir_next;
            x_major_reg   <= x_major_next;
            steps_reg     <= steps_next;
            pat_pos_reg   <= pat_pos_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                dash_reg <= cfg_wdata;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_vis_reg  <= out_vis_next;
        out_last_reg <= out_last_next;
        out_pv_reg   <= out_pv_next;
    end

    assign out_valid     = out_valid_reg;
    assign out_x         = out_x_reg;
    assign out_y         = out_y_reg;
    assign out_visible   = out_vis_reg;
    assign out_last      = out_last_reg;
    assign out_pix_valid = out_pv_reg;

endmodule

// File: hdl/midpoint_line_rasterizer_core.sv
// Midpoint line rasterizer, all octants, one pixel per input beat. A start beat
// (s_tuser = 0) loads two endpoints and returns the start pixel; a step beat
// (s_tuser = 1) returns the next pixel, and once the line is done returns an
// empty pixel with the valid flag in m_tuser low. Sustained rate is one beat per
// clock while m_tready stays high, set by the stepper, which updates the decision
// term with one add and sign test per cycle; a two-entry queue lets input and
// output stall independently. The user must write the dash pattern through
// cfg_we/cfg_wdata while the core is idle; the core itself does not enforce it.
// Depends on mlr_pkg, mlr_front, mlr_queue and mlr_stepper.
module midpoint_line_rasterizer_core
    import mlr_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int PATTERN_LEN = PATTERN_LEN_DEF,
    localparam int IN_W  = ((4 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Dash pattern register
    input  logic                 cfg_we,
    input  logic [DASH_BITS-1:0] cfg_wdata,
    // Input beats
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_W-1:0]      s_tdata,   // x_start, y_start, x_end, y_end
    input  logic                 s_tuser,   // action
    // Result beats
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OUT_W-1:0]     m_tdata,   // pixel_x, pixel_y
    output logic                 m_tlast,   // last_pixel
    output logic [1:0]           m_tuser    // visible, pixel_valid
);
    localparam int CW = COORD_BITS;
    localparam int MW = COORD_BITS + 1;
    localparam int QW = $bits(cmd_ctrl_t) + 2 * CW + 2 * MW;

    cmd_ctrl_t         f_ctrl, q_ctrl;
    logic [CW-1:0]     f_x0, f_y0, q_x0, q_y0;
    logic [MW-1:0]     f_major, f_minor, q_major, q_minor;
    logic [QW-1:0]     q_in_data, q_out_data;
    logic              q_valid, q_ready;
    logic [CW-1:0]     px, py;
    logic              vis, pix_valid;

    // Classify the incoming beat
    mlr_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .action (s_tuser),
        .x_start(s_tdata[CW-1:0]),
        .y_start(s_tdata[2*CW-1:CW]),
        .x_end  (s_tdata[3*CW-1:2*CW]),
        .y_end  (s_tdata[4*CW-1:3*CW]),
        .ctrl   (f_ctrl),
        .x0     (f_x0),
        .y0     (f_y0),
        .major  (f_major),
        .minor  (f_minor)
    );

    assign q_in_data = {f_ctrl, f_x0, f_y0, f_major, f_minor};

    // Decouple front and back
    mlr_queue #(
        .WIDTH(QW),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_data  (q_in_data),
        .out_valid(q_valid),
        .out_ready(q_ready),
        .out_data (q_out_data)
    );

    assign {q_ctrl, q_x0, q_y0, q_major, q_minor} = q_out_data;

    // Walk the line
    mlr_stepper #(
        .COORD_BITS (COORD_BITS),
        .PATTERN_LEN(PATTERN_LEN)
    ) u_stepper (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_ctrl       (q_ctrl),
        .q_x0         (q_x0),
        .q_y0         (q_y0),
        .q_major      (q_major),
        .q_minor      (q_minor),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_x        (px),
        .out_y        (py),
        .out_visible  (vis),
        .out_last     (m_tlast),
        .out_pix_valid(pix_valid)
    );

    assign m_tdata = OUT_W'({py, px});
    assign m_tuser = {pix_valid, vis};

endmodule

// File: hdl/mlr_checker.sv
// Port-level checks on the rasterizer result channel, bound to the top level.
// Depends on assert_macros.svh and mlr_pkg.
`include "assert_macros.svh"

module mlr_checker
    import mlr_pkg::*;
#(
    parameter int OUT_W = 24
) (
    input logic             aclk,
    input logic             aresetn,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic             m_tlast,
    input logic [1:0]       m_tuser
);

    // A stalled result beat holds
    `AST_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "result beat changed while stalled")

    // An empty pixel carries no coordinates and no flags
    `AST_IMPLIES(a_empty_clean, aclk, aresetn, m_tvalid && !m_tuser[1], m_tdata == '0 && !m_tlast && !m_tuser[0], "empty pixel carries data")

    // Only a real pixel can end a line
    `AST_IMPLIES(a_last_valid, aclk, aresetn, m_tvalid && m_tlast, m_tuser[1], "line end on empty pixel")

endmodule

bind midpoint_line_rasterizer_core mlr_checker #(
    .OUT_W(OUT_W)
) u_mlr_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)
);

// File: dv/midpoint_line_rasterizer_core_tb.sv
// Self-checking testbench for midpoint_line_rasterizer_core: directed and random line beats,
// checked pixel by pixel against an in-bench line stepper with its own dash pattern copy.
// Depends on mlr_pkg and the core RTL.
module midpoint_line_rasterizer_core_tb;
    import mlr_pkg::*;

    localparam int CW    = COORD_BITS_DEF;
    localparam int IN_W  = ((4 * CW + 7) / 8) * 8;
    localparam int OUT_W = ((2 * CW + 7) / 8) * 8;
    localparam int CMAX  = (1 << (CW - 1)) - 1;
    localparam int CMIN  = -(1 << (CW - 1));

    typedef logic signed [CW-1:0] coord_t;

    typedef struct {
        logic   action;
        coord_t x_start;
        coord_t y_start;
        coord_t x_end;
        coord_t y_end;
    } line_cmd_t;

    typedef struct {
        coord_t px;
        coord_t py;
        logic   visible;
        logic   last_pixel;
        logic   pixel_valid;
    } pixel_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [DASH_BITS-1:0] cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata   = '0;   // x_start, y_start, x_end, y_end
    logic                 s_tuser   = 1'b0; // action
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [OUT_W-1:0]     m_tdata;          // pixel_x, pixel_y
    logic                 m_tlast;          // last_pixel
    logic [1:0]           m_tuser;          // visible, pixel_valid

    // Stimulus and scoreboard bookkeeping
    line_cmd_t cmd_pending[$];
    pixel_t    pixel_expect[$];
    int        queued_cnt     = 0;
    int        accepted_cnt   = 0;
    int        mismatch_count = 0;
    int        idle_pct       = 28;
    bit        in_fire        = 1'b0;

    // Line stepper state, reset values
    logic [DASH_BITS-1:0] dash_reg      = DASH_RESET;
    coord_t               ln_x          = '0;
    coord_t               ln_y          = '0;
    logic signed [15:0]   ln_decision   = '0;
    logic [12:0]          ln_major      = '0;
    logic [12:0]          ln_minor      = '0;
    dir_t                 ln_x_dir      = DIR_NONE;
    dir_t                 ln_y_dir      = DIR_NONE;
    logic                 ln_x_major    = 1'b0;
    logic [12:0]          ln_steps_left = '0;
    int                   ln_pat_pos    = 0;

    midpoint_line_rasterizer_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Advance the line stepper by one beat and return the pixel it emits
    function automatic pixel_t next_pixel(line_cmd_t c);
        pixel_t p;
        int     dx, dy, adx, ady;
        p = '{px: '0, py: '0, visible: 1'b0, last_pixel: 1'b0, pixel_valid: 1'b0};
        if (c.action == ACT_START) begin
            dx  = int'(c.x_end) - int'(c.x_start);
            dy  = int'(c.y_end) - int'(c.y_start);
            adx = (dx < 0) ? -dx : dx;
            ady = (dy < 0) ? -dy : dy;
            ln_x          = c.x_start;
            ln_y          = c.y_start;
            ln_x_dir      = (dx > 0) ? DIR_POS : ((dx < 0) ? DIR_NEG : DIR_NONE);
            ln_y_dir      = (dy > 0) ? DIR_POS : ((dy < 0) ? DIR_NEG : DIR_NONE);
            ln_x_major    = (adx > ady);
            ln_major      = 13'(ln_x_major ? adx : ady);
            ln_minor      = 13'(ln_x_major ? ady : adx);
            ln_decision   = 16'(2 * int'(ln_minor) - int'(ln_major));
            ln_steps_left = ln_major;
            p = '{px: ln_x, py: ln_y, visible: 1'b1,
                  last_pixel: (ln_steps_left == 0), pixel_valid: 1'b1};
        end else if (ln_steps_left != 0) begin
            // Major axis always moves; minor axis follows the decision sign
            if (ln_x_major)
                ln_x = ln_x + ln_x_dir;
            else
                ln_y = ln_y + ln_y_dir;
            if (ln_decision < 0) begin
                ln_decision = 16'(int'(ln_decision) + 2 * int'(ln_minor));
            end else begin
                if (ln_x_major)
                    ln_y = ln_y + ln_y_dir;
                else
                    ln_x = ln_x + ln_x_dir;
                ln_decision = 16'(int'(ln_decision) + 2 * (int'(ln_minor) - int'(ln_major)));
            end
            ln_steps_left = ln_steps_left - 1'b1;
            // Dash position keeps running from one line into the next
            p.visible  = (ln_pat_pos < DASH_BITS) ? dash_reg[ln_pat_pos] : 1'b0;
            ln_pat_pos = (ln_pat_pos + 1) % PATTERN_LEN_DEF;
            p.px          = ln_x;
            p.py          = ln_y;
            p.last_pixel  = (ln_steps_left == 0);
            p.pixel_valid = 1'b1;
        end
        return p;
    endfunction

    task automatic flag_mismatch(string msg);
        mismatch_count++;
        $display("[%0t] pixel check: %s", $time, msg);
    endtask

    // Sample both channels and the config port at the rising edge
    always @(posedge aclk) begin
        pixel_t    got;
        pixel_t    want;
        line_cmd_t cmd;
        in_fire = aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = '{px: m_tdata[CW-1:0], py: m_tdata[2*CW-1:CW], visible: m_tuser[0],
                        last_pixel: m_tlast, pixel_valid: m_tuser[1]};
                if (pixel_expect.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result beat x=%0d y=%0d",
                                            got.px, got.py));
                end else begin
                    want = pixel_expect.pop_front();
                    if (got.px !== want.px)
                        flag_mismatch($sformatf("pixel_x %0d, want %0d", got.px, want.px));
                    if (got.py !== want.py)
                        flag_mismatch($sformatf("pixel_y %0d, want %0d", got.py, want.py));
                    if (got.visible !== want.visible)
                        flag_mismatch($sformatf("visible %b, want %b",
                                                got.visible, want.visible));
                    if (got.last_pixel !== want.last_pixel)
                        flag_mismatch($sformatf("last_pixel %b, want %b",
                                                got.last_pixel, want.last_pixel));
                    if (got.pixel_valid !== want.pixel_valid)
                        flag_mismatch($sformatf("pixel_valid %b, want %b",
                                                got.pixel_valid, want.pixel_valid));
                end
            end
            if (in_fire) begin
                cmd.action  = s_tuser;
                cmd.x_start = s_tdata[CW-1:0];
                cmd.y_start = s_tdata[2*CW-1:CW];
                cmd.x_end   = s_tdata[3*CW-1:2*CW];
                cmd.y_end   = s_tdata[4*CW-1:3*CW];
                pixel_expect.insert(pixel_expect.size(), next_pixel(cmd));
                accepted_cnt++;
            end
            if (cfg_we)
                dash_reg = cfg_wdata;
        end
    end

    // Drive input beats and output backpressure on the falling edge
    always @(negedge aclk) begin
        line_cmd_t c;
        if (aresetn && (!s_tvalid || in_fire)) begin
            if (cmd_pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
                c = cmd_pending.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= c.action;
                s_tdata  <= IN_W'({c.y_end, c.x_end, c.y_start, c.x_start});
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= aresetn && ($urandom_range(99) >= idle_pct);
    end

    task automatic push_cmd(logic action, int xs, int ys, int xe, int ye);
        line_cmd_t c;
        c.action  = action;
        c.x_start = coord_t'(xs);
        c.y_start = coord_t'(ys);
        c.x_end   = coord_t'(xe);
        c.y_end   = coord_t'(ye);
        cmd_pending.insert(cmd_pending.size(), c);
        queued_cnt++;
    endtask

    // Step beats carry random junk in the ignored coordinate fields
    task automatic push_step();
        push_cmd(ACT_STEP, int'($urandom), int'($urandom), int'($urandom), int'($urandom));
    endtask

    task automatic push_line(int xs, int ys, int xe, int ye, int n_steps);
        push_cmd(ACT_START, xs, ys, xe, ye);
        repeat (n_steps) push_step();
    endtask

    function automatic int rand_coord();
        return int'($urandom_range(CMAX - CMIN)) + CMIN;
    endfunction

    // Move mag away from base in a random direction, flipping to stay in range
    function automatic int offset_coord(int base, int mag);
        int v;
        v = $urandom_range(1) ? base + mag : base - mag;
        if (v > CMAX || v < CMIN)
            v = 2 * base - v;
        return v;
    endfunction

    // Mostly complete short lines, some long ones, aborted lines and stray steps
    task automatic push_random(int n);
        int first, r, x0, y0, lim, mx, my, major;
        first = queued_cnt;
        while (queued_cnt - first < n) begin
            r  = $urandom_range(99);
            x0 = rand_coord();
            y0 = rand_coord();
            if (r < 75) begin
                lim   = ($urandom_range(9) == 0) ? 200 : 12;
                mx    = $urandom_range(lim);
                my    = $urandom_range(lim);
                major = (mx > my) ? mx : my;
                if ($urandom_range(3) == 0)
                    major += $urandom_range(1, 2);
                push_line(x0, y0, offset_coord(x0, mx), offset_coord(y0, my), major);
            end else if (r < 90) begin
                push_line(x0, y0, rand_coord(), rand_coord(), $urandom_range(6));
            end else begin
                repeat ($urandom_range(1, 3)) push_step();
            end
        end
    endtask

    task automatic wait_drained();
        while (accepted_cnt != queued_cnt || pixel_expect.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_dash(logic [DASH_BITS-1:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        logic [DASH_BITS-1:0] dash_plan[6];
        dash_plan = '{4'h0, 4'hA, 4'h5, 4'(DASH_RESET), 4'h3, 4'h0};
        dash_plan[4] = 4'($urandom);
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: empty step, point line, extreme endpoints, several octants
        push_step();
        push_line(7, -3, 7, -3, 1);
        push_line(CMIN, CMIN, CMAX, CMAX, 2);
        push_line(CMAX, CMAX, CMIN, CMIN, 1);
        push_line(0, 0, 3, 1, 4);
        push_line(1, 2, 0, -1, 4);
        push_line(5, 0, 2, 0, 3);
        push_line(0, 0, -2, 2, 2);
        push_random(200);
        wait_drained();

        // Sweep dash settings; hold the sender off until each phase drains
        for (int i = 0; i < 6; i++) begin
            idle_pct = (i == 2) ? 0 : 28;
            write_dash(dash_plan[i]);
            push_random(200);
            wait_drained();
        end

        repeat (8) @(negedge aclk);
        if (pixel_expect.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", pixel_expect.size()));
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog for a hung handshake
    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
